// ===== rtl/run_limited_binary_rank_unrank_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the run-limited binary rank/unrank block
// Each macro checks at the rising edge of clk and is off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RUN_LIMITED_BINARY_RANK_UNRANK_MACROS_SVH
`define RUN_LIMITED_BINARY_RANK_UNRANK_MACROS_SVH
`ifndef SYNTHESIS
`define RLBRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLBRU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RLBRU_ASSERT(lbl, prop, msg)
`define RLBRU_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/rlbru_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbru_pkg
// Shared widths, default parameter values and request codes.
// ----------------------------------------------------------------------------
package rlbru_pkg;

  localparam int OPERAND_W       = 60;
  localparam int VALUE_W         = 61;
  localparam int SEARCH_BITS_DEF = 60;

  // Request codes carried on req_type.
  localparam logic REQ_COUNT  = 1'b0;
  localparam logic REQ_UNRANK = 1'b1;

endpackage

// ===== rtl/rlbru_ifs.sv =====
// ----------------------------------------------------------------------------
// rlbru channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rlbru_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [rlbru_pkg::OPERAND_W-1:0] operand;

  modport source (output valid, output req_type, output operand, input ready);
  modport sink (input valid, input req_type, input operand, output ready);
endinterface

interface rlbru_out_if;
  logic                          valid;
  logic                          ready;
  logic [rlbru_pkg::VALUE_W-1:0] value;
  logic                          saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink (input valid, input value, input saturated, output ready);
endinterface

// ===== rtl/rlbru_count_dp.sv =====
// ----------------------------------------------------------------------------
// rlbru_count_dp
// Bit-serial counter of valid integers in [0, x], one bit of x per cycle.
// ----------------------------------------------------------------------------
module rlbru_count_dp #(
  parameter int XW = rlbru_pkg::VALUE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [XW-1:0] x,
  output logic          done,
  output logic [XW-1:0] count
);

  localparam int PW = $clog2(XW);

  // Tight path state: no set bit yet, or last bit and its run length.
  typedef enum logic [2:0] {TS_NONE, TS_A1, TS_A2, TS_B1, TS_B2} tstate_t;
  typedef enum logic [1:0] {PH_IDLE, PH_STEP, PH_SUM1, PH_SUM2} phase_t;

  phase_t        phase_r;
  logic [PW-1:0] pos_r;
  logic [XW-1:0] x_sr_r;
  logic [XW-1:0] n_r, a1_r, a2_r, b1_r, b2_r, acc_r;
  logic          alive_r;
  tstate_t       ts_r;
  logic          done_r;
  logic [XW-1:0] count_r;

  logic          bit_w;
  tstate_t       ts_nxt;
  logic          t_ok;
  logic          inc_n, inc_a1, inc_a2;
  logic [XW-1:0] n_nxt, a1_nxt, a2_nxt, b1_nxt;

  assign bit_w = x_sr_r[XW-1];

  // Tight path: the digit equal to the bound bit keeps it tight; a zero under
  // a one in the bound leaves the tight path and joins the loose counts.
  always_comb begin
    ts_nxt = ts_r;
    t_ok   = 1'b1;
    inc_n  = 1'b0;
    inc_a1 = 1'b0;
    inc_a2 = 1'b0;
    case (ts_r)
      TS_NONE: begin
        ts_nxt = bit_w ? TS_B1 : TS_NONE;
        inc_n  = bit_w;
      end
      TS_A1: begin
        ts_nxt = bit_w ? TS_B1 : TS_A2;
        inc_a2 = bit_w;
      end
      TS_A2: begin
        ts_nxt = TS_B1;
        t_ok   = bit_w;
      end
      TS_B1: begin
        ts_nxt = bit_w ? TS_B2 : TS_A1;
        inc_a1 = bit_w;
      end
      TS_B2: begin
        ts_nxt = TS_A1;
        t_ok   = !bit_w;
        inc_a1 = bit_w;
      end
      default: begin
        ts_nxt = TS_NONE;
        t_ok   = 1'b0;
      end
    endcase
  end

  // Loose counts: a run of three equal bits is dropped.
  assign n_nxt  = n_r + XW'(inc_n & alive_r);
  assign a1_nxt = b1_r + b2_r + XW'(inc_a1 & alive_r);
  assign a2_nxt = a1_r + XW'(inc_a2 & alive_r);
  assign b1_nxt = n_r + a1_r + a2_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          x_sr_r  <= x;
          pos_r   <= PW'(XW - 1);
          n_r     <= '0;
          a1_r    <= '0;
          a2_r    <= '0;
          b1_r    <= '0;
          b2_r    <= '0;
          alive_r <= 1'b1;
          ts_r    <= TS_NONE;
          phase_r <= PH_STEP;
        end
      end
      PH_STEP: begin
        x_sr_r  <= {x_sr_r[XW-2:0], 1'b0};
        n_r     <= n_nxt;
        a1_r    <= a1_nxt;
        a2_r    <= a2_nxt;
        b1_r    <= b1_nxt;
        b2_r    <= b1_r;
        alive_r <= alive_r & t_ok;
        ts_r    <= ts_nxt;
        pos_r   <= pos_r - 1'b1;
        if (pos_r == '0) begin
          phase_r <= PH_SUM1;
        end
      end
      PH_SUM1: begin
        acc_r   <= n_r + a1_r + a2_r + XW'(alive_r);
        phase_r <= PH_SUM2;
      end
      PH_SUM2: begin
        count_r <= acc_r + b1_r + b2_r;
        done_r  <= 1'b1;
        phase_r <= PH_IDLE;
      end
      default: begin
        phase_r <= PH_IDLE;
      end
    endcase
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end
  end

  assign done  = done_r;
  assign count = count_r;

endmodule

// ===== rtl/run_limited_binary_rank_unrank.sv =====
// ----------------------------------------------------------------------------
// run_limited_binary_rank_unrank
// Counts or ranks integers whose binary form has no run of three equal bits.
// ----------------------------------------------------------------------------
// Count request: one bit-serial walk of the counting engine over the XW bound
//   bits of the operand.
// Rank request: a binary search over [0, 2^SEARCH_BITS], with one full
//   bit-serial count per binary-search probe.
// One item in flight: a request is taken only while idle. A result waiting in
//   the output register does not block the next item; a second result then holds the block until that register is free.
// Reset: synchronous, active low; clears the sequencer and the output valid.

`include "run_limited_binary_rank_unrank_macros.svh"

module run_limited_binary_rank_unrank #(
  parameter int SEARCH_BITS = rlbru_pkg::SEARCH_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rlbru_in_if.sink     in_ch,
  rlbru_out_if.source  out_ch
);

  // Width of the search interval bounds, which reach 2^SEARCH_BITS.
  localparam int SW = SEARCH_BITS + 1;
  // Width of the counted bound and of every count: wide enough for both a
  // full operand and the top of the search interval.
  localparam int XW = (SW > rlbru_pkg::VALUE_W) ? SW : rlbru_pkg::VALUE_W;

  typedef enum logic [1:0] {S_IDLE, S_MID, S_RUN, S_OUT} state_t;

  state_t                       state_r;
  logic                         mode_r;
  logic [SW-1:0]                lo_r, hi_r, mid_r;
  logic [rlbru_pkg::VALUE_W-1:0] target_r;
  logic                         start_r;
  logic [XW-1:0]                x_r;
  logic [rlbru_pkg::VALUE_W-1:0] res_value_r;
  logic                         res_sat_r;
  logic                         out_valid_r;
  logic [rlbru_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_sat_r;

  logic                         dp_done;
  logic [XW-1:0]                dp_count;
  logic [SW:0]                  mid_sum;
  logic                         hit;

  // The counting engine walks the bound from its top bit, one bit per cycle.
  rlbru_count_dp #(
    .XW (XW)
  ) u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .x     (x_r),
    .done  (dp_done),
    .count (dp_count)
  );

  // Midpoint of [lo, hi]; floor((lo + hi) / 2) equals lo + (hi - lo) / 2 here.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  // The probe meets the rank when at least rank + 1 valid integers lie at or
  // below it.
  assign hit     = dp_count >= XW'(target_r);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.saturated = out_sat_r;

  always_ff @(posedge clk) begin
    start_r <= 1'b0;
    if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_r   <= in_ch.req_type;
          lo_r     <= '0;
          hi_r     <= {1'b1, {SEARCH_BITS{1'b0}}};
          target_r <= {1'b0, in_ch.operand} + 1'b1;
          if (in_ch.req_type == rlbru_pkg::REQ_COUNT) begin
            // A count is one pass of the engine over the operand itself.
            x_r     <= XW'(in_ch.operand);
            start_r <= 1'b1;
            state_r <= S_RUN;
          end else begin
            state_r <= S_MID;
          end
        end
      end
      S_MID: begin
        if (lo_r < hi_r) begin
          mid_r   <= mid_sum[SW:1];
          x_r     <= XW'(mid_sum[SW:1]);
          start_r <= 1'b1;
          state_r <= S_RUN;
        end else begin
          // The search has closed; reaching the top bound means no valid
          // integer of that rank exists below 2^SEARCH_BITS.
          res_value_r <= rlbru_pkg::VALUE_W'(lo_r);
          res_sat_r   <= lo_r[SEARCH_BITS];
          state_r     <= S_OUT;
        end
      end
      S_RUN: begin
        if (dp_done) begin
          if (mode_r == rlbru_pkg::REQ_COUNT) begin
            res_value_r <= rlbru_pkg::VALUE_W'(dp_count);
            res_sat_r   <= 1'b0;
            state_r     <= S_OUT;
          end else begin
            if (hit) begin
              hi_r <= mid_r;
            end else begin
              lo_r <= mid_r + 1'b1;
            end
            state_r <= S_MID;
          end
        end
      end
      S_OUT: begin
        // The result moves to the output register once that slot is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          out_value_r <= res_value_r;
          out_sat_r   <= res_sat_r;
          state_r     <= S_IDLE;
        end
      end
      default: begin
        state_r <= S_IDLE;
      end
    endcase
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end
  end

  `RLBRU_ASSERT(a_done_in_run, dp_done |-> state_r == S_RUN, "engine finished outside a probe")
  `RLBRU_ASSERT(a_interval, state_r == S_MID |-> lo_r <= hi_r, "search interval inverted")
  `RLBRU_ASSERT_NEVER(a_sat_mode, state_r == S_OUT && res_sat_r && mode_r == rlbru_pkg::REQ_COUNT, "saturation flagged on a count")
  `RLBRU_ASSERT(a_start_run, start_r |-> state_r == S_RUN, "engine started outside a probe")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for run_limited_binary_rank_unrank
// Sends count and rank requests over the valid/ready request channel, predicts
// every result with a software digit walk and binary search, and compares the
// results field by field as they come out, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  // The rank search spans [0, 2^SEARCH_W], matching the block's default build.
  localparam int SEARCH_W = rlbru_pkg::SEARCH_BITS_DEF;

  // The slowest correct run is 140 requests, each a full rank search followed
  // by the longest sender gap and receiver stall. The limit is several times
  // that run's length.
  localparam int LIMIT_CYCLES = 3000000;

  // This settle time covers the result of one more count request.
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic                           req_type;
    logic [rlbru_pkg::OPERAND_W-1:0] operand;
    bit                             hold_for_drain;
  } request_t;

  typedef struct {
    logic [rlbru_pkg::VALUE_W-1:0] value;
    logic                         saturated;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  rlbru_in_if  in_ch ();
  rlbru_out_if out_ch ();

  run_limited_binary_rank_unrank DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests still to be sent, and results predicted for accepted requests.
  request_t pending_reqs[$];
  result_t  expected_results[$];

  int       mismatches = 0;
  int       cycle_count = 0;
  bit [63:0] valid_total;

  // Driver and monitor state.
  int       tx_idle = 0;
  bit       tx_calm = 1'b0;
  int       rx_stall = 0;
  bit       rx_calm = 1'b0;
  request_t next_req;
  result_t  want;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Number of valid integers in [0, bound]. The walk goes from the top set bit
  // down, tracking the previous bit (none, 0 or 1), the length of the current
  // run (1 or 2) and whether the prefix so far equals the bound's prefix.
  // Leading zeros keep the walk in the "none" state, which is how zero and all
  // shorter numbers get counted.
  function automatic bit [63:0] count_valid_upto(bit [63:0] bound);
    bit [63:0] cur [3][3][2];
    bit [63:0] nxt [3][3][2];
    bit [63:0] total;
    int        msb;
    int        maxd;
    int        new_run;
    int        nt;
    bit        b;
    if (bound == 0) return 64'd1;
    msb = 63;
    while (!bound[msb]) msb--;
    for (int p = 0; p < 3; p++)
      for (int r = 0; r < 3; r++)
        for (int t = 0; t < 2; t++) cur[p][r][t] = '0;
    cur[0][0][1] = 64'd1;
    for (int pos = msb; pos >= 0; pos--) begin
      b = bound[pos];
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          for (int t = 0; t < 2; t++) nxt[p][r][t] = '0;
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          for (int t = 0; t < 2; t++) begin
            if (cur[p][r][t] != 0) begin
              maxd = (t != 0) ? int'(b) : 1;
              for (int d = 0; d <= maxd; d++) begin
                nt = (t != 0 && d == maxd) ? 1 : 0;
                if (p == 0 && d == 0) begin
                  nxt[0][0][nt] += cur[p][r][t];
                end else begin
                  new_run = (p == d + 1) ? r + 1 : 1;
                  // A third equal bit in a row makes the number invalid.
                  if (new_run < 3) nxt[d + 1][new_run][nt] += cur[p][r][t];
                end
              end
            end
          end
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          for (int t = 0; t < 2; t++) cur[p][r][t] = nxt[p][r][t];
    end
    total = '0;
    for (int p = 0; p < 3; p++)
      for (int r = 0; r < 3; r++)
        for (int t = 0; t < 2; t++) total += cur[p][r][t];
    return total;
  endfunction

  // Expected result of one request. A rank request looks for the smallest x
  // in [0, 2^SEARCH_W] whose count reaches rank + 1; ending on the top bound
  // means the rank lies beyond every valid number of SEARCH_W bits.
  function automatic result_t predict_result(logic req_type,
                                             logic [rlbru_pkg::OPERAND_W-1:0] operand);
    result_t   res;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] mid;
    bit [63:0] top;
    bit [63:0] target;
    bit [63:0] cnt;
    top = 64'd1 << SEARCH_W;
    res.saturated = 1'b0;
    if (req_type == rlbru_pkg::REQ_COUNT) begin
      cnt = count_valid_upto(64'(operand));
      res.value = cnt[rlbru_pkg::VALUE_W-1:0];
    end else begin
      lo = '0;
      hi = top;
      target = 64'(operand) + 64'd1;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (count_valid_upto(mid) >= target) hi = mid;
        else lo = mid + 64'd1;
      end
      res.value = lo[rlbru_pkg::VALUE_W-1:0];
      res.saturated = (lo == top);
    end
    return res;
  endfunction

  function automatic logic [rlbru_pkg::OPERAND_W-1:0] rand_operand();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[rlbru_pkg::OPERAND_W-1:0];
  endfunction

  // Idle length for either side: mostly none or short, now and then long, and
  // nothing at all while the side is in a calm stretch.
  function automatic int draw_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic add_req(logic req_type, logic [rlbru_pkg::OPERAND_W-1:0] operand);
    request_t req;
    req.req_type = req_type;
    req.operand = operand;
    req.hold_for_drain = 1'b0;
    pending_reqs = {pending_reqs, req};
  endtask

  // The sender holds at this marker until every accepted item has its result.
  task automatic add_drain();
    request_t req;
    req.req_type = rlbru_pkg::REQ_COUNT;
    req.operand = '0;
    req.hold_for_drain = 1'b1;
    pending_reqs = {pending_reqs, req};
  endtask

  // Request driver. The expectation is computed at the edge where the item is
  // accepted, from the fields on the channel at that edge. A new item, or the
  // end of valid, is driven only when the channel slot is free.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.req_type <= rlbru_pkg::REQ_COUNT;
      in_ch.operand  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results = {expected_results,
                            predict_result(in_ch.req_type, in_ch.operand)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && pending_reqs[0].hold_for_drain) begin
          in_ch.valid <= 1'b0;
          if (expected_results.size() == 0) void'(pending_reqs.pop_front());
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.req_type <= next_req.req_type;
          in_ch.operand  <= next_req.operand;
          if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
          tx_idle = draw_gap(tx_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted result is checked against the oldest
  // expectation; ready drops at random, both while a result waits and while
  // the block is still working.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: value=%0d saturated=%0b",
                 out_ch.value, out_ch.saturated);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_ch.value);
            mismatches++;
          end
          if (out_ch.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated,
                   out_ch.saturated);
            mismatches++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        if ($urandom_range(0, 15) == 0) rx_stall = draw_gap(rx_calm);
        out_ch.ready <= (rx_stall == 0);
      end
    end
  end

  // Run limit: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int        pick;
    logic [rlbru_pkg::OPERAND_W-1:0] op;
    bit [63:0] rank;

    // Every input is known from time zero.
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = rlbru_pkg::REQ_COUNT;
    in_ch.operand = '0;
    out_ch.ready = 1'b0;

    // Count of valid numbers below 2^SEARCH_W, zero included; a rank equal to
    // it is the first one that saturates.
    valid_total = count_valid_upto((64'd1 << SEARCH_W) - 64'd1);

    // Directed part. Counts: zero (count of one), small bounds around the
    // first invalid numbers, a lone top bit, alternating and 110 patterns, and
    // all ones.
    add_req(rlbru_pkg::REQ_COUNT, '0);
    add_req(rlbru_pkg::REQ_COUNT, 60'd1);
    add_req(rlbru_pkg::REQ_COUNT, 60'd3);
    add_req(rlbru_pkg::REQ_COUNT, 60'd4);
    add_req(rlbru_pkg::REQ_COUNT, 60'd7);
    add_req(rlbru_pkg::REQ_COUNT, 60'd8);
    add_req(rlbru_pkg::REQ_COUNT, 60'h800000000000000);
    add_req(rlbru_pkg::REQ_COUNT, 60'hAAAAAAAAAAAAAAA);
    add_req(rlbru_pkg::REQ_COUNT, 60'h555555555555555);
    add_req(rlbru_pkg::REQ_COUNT, 60'hDB6DB6DB6DB6DB6);
    add_req(rlbru_pkg::REQ_COUNT, '1);
    // Ranks: zero, small ranks, the largest valid number that fits, the first two
    // ranks beyond it, and the all-ones rank.
    add_req(rlbru_pkg::REQ_UNRANK, '0);
    add_req(rlbru_pkg::REQ_UNRANK, 60'd1);
    add_req(rlbru_pkg::REQ_UNRANK, 60'd2);
    add_req(rlbru_pkg::REQ_UNRANK, 60'd5);
    add_req(rlbru_pkg::REQ_UNRANK, rlbru_pkg::OPERAND_W'(valid_total - 64'd1));
    add_req(rlbru_pkg::REQ_UNRANK, rlbru_pkg::OPERAND_W'(valid_total));
    add_req(rlbru_pkg::REQ_UNRANK, rlbru_pkg::OPERAND_W'(valid_total + 64'd1));
    add_req(rlbru_pkg::REQ_UNRANK, '1);
    add_drain();

    // Random part. Counts use bounds of every length; most ranks fall inside
    // the valid range, some sit right at its top edge and some are full-width
    // values, which nearly always saturate.
    for (int i = 0; i < 121; i++) begin
      if (i == 60) add_drain();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_req(rlbru_pkg::REQ_COUNT,
                rand_operand() >> $urandom_range(0, rlbru_pkg::OPERAND_W - 1));
      end else if (pick < 85) begin
        rank = 64'(rand_operand() >> $urandom_range(17, rlbru_pkg::OPERAND_W - 1));
        if (rank >= valid_total) rank = rank % valid_total;
        add_req(rlbru_pkg::REQ_UNRANK, rlbru_pkg::OPERAND_W'(rank));
      end else if (pick < 90) begin
        rank = valid_total - 64'd26 + 64'($urandom_range(0, 50));
        add_req(rlbru_pkg::REQ_UNRANK, rlbru_pkg::OPERAND_W'(rank));
      end else begin
        op = rand_operand();
        add_req(rlbru_pkg::REQ_UNRANK, op);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to be taken and every result to come back, then
    // give a stray result time to show up.
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
